// File: design/cms_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the complex magnitude statistics block.
// Used by cms_ctrl, cms_datapath and complex_magnitude_statistics.

package cms_pkg;

    localparam int IN_W              = 16;
    localparam int MAG_W             = 16;
    localparam int SQ_W              = 2 * MAG_W;
    localparam int REM_W             = MAG_W + 2;
    localparam int VAR_W             = 29;
    localparam int CNT_OUT_W         = 11;
    localparam int ROOT_STEPS        = MAG_W;
    localparam int DIV_SHIFT         = VAR_W - 1;
    localparam int STEP_W            = $clog2(VAR_W);
    localparam int MAX_ITEMS_DEFAULT = 1024;

    typedef struct packed {
        logic signed [IN_W-1:0] real_part;
        logic signed [IN_W-1:0] imag_part;
        logic                   last;
    } cms_in_t;

    typedef struct packed {
        logic [MAG_W-1:0]     min_magnitude;
        logic [MAG_W-1:0]     max_magnitude;
        logic [MAG_W-1:0]     mean_magnitude;
        logic [VAR_W-1:0]     magnitude_variance;
        logic [CNT_OUT_W-1:0] sample_count;
        logic                 overflowed;
    } cms_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_ROOT,
        ST_UPDATE,
        ST_FIN_START,
        ST_FIN_NSQ,
        ST_FIN_SSQ,
        ST_FIN_NN,
        ST_DIV_MEAN,
        ST_DIV_VAR
    } cms_state_t;

    typedef enum logic [1:0] {
        MUL_NSQ,
        MUL_SSQ,
        MUL_NN
    } cms_mul_sel_t;

    typedef enum logic {
        DIV_MEAN,
        DIV_VAR
    } cms_div_sel_t;

    typedef struct packed {
        logic         capture;
        logic         mark_overflow;
        logic         sq_first;
        logic         sq_second;
        logic         root_step;
        logic         update;
        logic         mul_load;
        cms_mul_sel_t mul_sel;
        logic         mul_step;
        logic         nsq_save;
        logic         ssq_sub;
        logic         div_load;
        cms_div_sel_t div_sel;
        logic         div_step;
        logic         mean_save;
        logic         emit;
    } cms_cmd_t;

    typedef struct packed {
        logic count_full;
        logic last_item;
        logic mul_last;
    } cms_status_t;

endpackage

// File: design/cms_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the complex magnitude statistics block.
// Drives cms_datapath through cms_pkg command and status structs.

module cms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                last,
    input  cms_pkg::cms_status_t status,
    output logic                busy,
    output cms_pkg::cms_cmd_t   cmd
);
    import cms_pkg::*;

    cms_state_t          state_reg;
    cms_state_t          state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_NSQ;
        cmd.div_sel = DIV_MEAN;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (status.count_full)
                    begin
                        // drop the item, but a last mark still closes the set
                        cmd.mark_overflow = 1'b1;
                        if (last)
                            state_next = ST_FIN_START;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_SQ_RE;
                    end
                end
            end
            ST_SQ_RE:
            begin
                cmd.sq_first = 1'b1;
                state_next   = ST_SQ_IM;
            end
            ST_SQ_IM:
            begin
                cmd.sq_second = 1'b1;
                step_next     = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (status.last_item)
                    state_next = ST_FIN_START;
                else
                    state_next = ST_IDLE;
            end
            ST_FIN_START:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = MUL_NSQ;
                state_next   = ST_FIN_NSQ;
            end
            ST_FIN_NSQ:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_last)
                begin
                    cmd.nsq_save = 1'b1;
                    cmd.mul_load = 1'b1;
                    cmd.mul_sel  = MUL_SSQ;
                    state_next   = ST_FIN_SSQ;
                end
            end
            ST_FIN_SSQ:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_last)
                begin
                    cmd.ssq_sub  = 1'b1;
                    cmd.mul_load = 1'b1;
                    cmd.mul_sel  = MUL_NN;
                    state_next   = ST_FIN_NN;
                end
            end
            ST_FIN_NN:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_last)
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_sel  = DIV_MEAN;
                    step_next    = '0;
                    state_next   = ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(VAR_W - 1))
                begin
                    cmd.mean_save = 1'b1;
                    cmd.div_load  = 1'b1;
                    cmd.div_sel   = DIV_VAR;
                    step_next     = '0;
                    state_next    = ST_DIV_VAR;
                end
            end
            ST_DIV_VAR:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(VAR_W - 1))
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: design/cms_datapath.sv
`timescale 1ns / 1ps
// Datapath: squaring, bit-per-cycle square root, running statistics,
// shift-add multiplier and restoring divider. Depends on cms_pkg.

module cms_datapath #(
    parameter int MAX_ITEMS = cms_pkg::MAX_ITEMS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cms_pkg::cms_in_t     item,
    input  cms_pkg::cms_cmd_t    cmd,
    output cms_pkg::cms_status_t status,
    output logic                 done,
    output cms_pkg::cms_out_t    result
);
    import cms_pkg::*;

    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int SW   = CW + MAG_W;
    localparam int QW   = CW + 2 * MAG_W;
    localparam int NUMW = 2 * CW + 2 * MAG_W;

    cms_in_t           in_reg;
    logic [SQ_W-1:0]   x_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [MAG_W-1:0]  root_reg;

    logic [CW-1:0]     count_reg;
    logic [SW-1:0]     sum_reg;
    logic [QW-1:0]     sumsq_reg;
    logic [MAG_W-1:0]  min_reg;
    logic [MAG_W-1:0]  max_reg;
    logic              ovf_reg;

    logic [NUMW-1:0]   acc_reg;
    logic [NUMW-1:0]   mcand_reg;
    logic [SW-1:0]     mplier_reg;
    logic [NUMW-1:0]   num_reg;
    logic [NUMW-1:0]   drem_reg;
    logic [NUMW-1:0]   dsr_reg;
    logic [VAR_W-1:0]  quo_reg;
    logic [MAG_W-1:0]  mean_reg;

    cms_out_t          result_reg;
    logic              done_reg;

    logic [IN_W-1:0]   re_u;
    logic [IN_W-1:0]   im_u;
    logic [MAG_W-1:0]  abs_re;
    logic [MAG_W-1:0]  abs_im;
    logic [MAG_W-1:0]  sq_op;
    logic [SQ_W-1:0]   sq_prod;

    logic [REM_W+1:0]  trial_rem;
    logic [REM_W+1:0]  trial;
    logic              root_ge;
    logic [REM_W+1:0]  root_diff;

    logic [NUMW-1:0]   acc_stepped;
    logic              div_ge;
    logic [VAR_W-1:0]  quo_stepped;
    logic              empty;

    // magnitude of a two's complement value; the most negative one maps to 2^15
    assign re_u   = in_reg.real_part;
    assign im_u   = in_reg.imag_part;
    assign abs_re = in_reg.real_part[IN_W-1] ? MAG_W'(~re_u + 1'b1) : MAG_W'(re_u);
    assign abs_im = in_reg.imag_part[IN_W-1] ? MAG_W'(~im_u + 1'b1) : MAG_W'(im_u);

    // one 16x16 squarer shared by re^2, im^2 and mag^2
    always_comb
    begin
        if (cmd.sq_first)
            sq_op = abs_re;
        else if (cmd.sq_second)
            sq_op = abs_im;
        else
            sq_op = root_reg;
    end
    assign sq_prod = SQ_W'(sq_op) * SQ_W'(sq_op);

    // bring down the next two radicand bits, try root*4+1
    assign trial_rem = {rem_reg, x_reg[SQ_W-1 -: 2]};
    assign trial     = (REM_W + 2)'({root_reg, 2'b01});
    assign root_ge   = (trial_rem >= trial);
    assign root_diff = trial_rem - trial;

    assign acc_stepped = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign div_ge      = (drem_reg >= dsr_reg);
    assign quo_stepped = {quo_reg[VAR_W-2:0], div_ge};
    assign empty       = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            in_reg <= item;

        if (cmd.sq_first)
            x_reg <= sq_prod;
        else if (cmd.sq_second)
            x_reg <= x_reg + sq_prod;
        else if (cmd.root_step)
            x_reg <= {x_reg[SQ_W-3:0], 2'b00};

        if (cmd.sq_second)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            if (root_ge)
            begin
                rem_reg  <= REM_W'(root_diff);
                root_reg <= {root_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(trial_rem);
                root_reg <= {root_reg[MAG_W-2:0], 1'b0};
            end
        end

        // shift-add multiplier, one multiplier bit per cycle
        if (cmd.mul_load)
        begin
            acc_reg <= '0;
            case (cmd.mul_sel)
                MUL_NSQ:
                begin
                    mcand_reg  <= NUMW'(sumsq_reg);
                    mplier_reg <= SW'(count_reg);
                end
                MUL_SSQ:
                begin
                    mcand_reg  <= NUMW'(sum_reg);
                    mplier_reg <= sum_reg;
                end
                MUL_NN:
                begin
                    mcand_reg  <= NUMW'(count_reg);
                    mplier_reg <= SW'(count_reg);
                end
                default:
                begin
                    mcand_reg  <= '0;
                    mplier_reg <= '0;
                end
            endcase
        end
        else if (cmd.mul_step)
        begin
            acc_reg    <= acc_stepped;
            mcand_reg  <= {mcand_reg[NUMW-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[SW-1:1]};
        end

        // n*sum_sq first, then subtract sum^2 in place
        if (cmd.nsq_save)
            num_reg <= acc_stepped;
        else if (cmd.ssq_sub)
            num_reg <= num_reg - acc_stepped;

        // restoring divider, divisor starts shifted to the top quotient bit
        if (cmd.div_load)
        begin
            case (cmd.div_sel)
                DIV_MEAN:
                begin
                    drem_reg <= NUMW'(sum_reg);
                    dsr_reg  <= NUMW'(count_reg) << DIV_SHIFT;
                end
                DIV_VAR:
                begin
                    drem_reg <= num_reg;
                    dsr_reg  <= acc_reg << DIV_SHIFT;
                end
                default:
                begin
                    drem_reg <= '0;
                    dsr_reg  <= '0;
                end
            endcase
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
                drem_reg <= drem_reg - dsr_reg;
            dsr_reg <= {1'b0, dsr_reg[NUMW-1:1]};
            quo_reg <= quo_stepped;
        end

        if (cmd.mean_save)
            mean_reg <= quo_stepped[MAG_W-1:0];

        if (cmd.emit)
        begin
            result_reg.min_magnitude      <= empty ? '0 : min_reg;
            result_reg.max_magnitude      <= empty ? '0 : max_reg;
            result_reg.mean_magnitude     <= empty ? '0 : mean_reg;
            result_reg.magnitude_variance <= empty ? '0 : quo_stepped;
            result_reg.sample_count       <= CNT_OUT_W'(count_reg);
            result_reg.overflowed         <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.emit)
            begin
                // clear for the next set
                count_reg <= '0;
                sum_reg   <= '0;
                sumsq_reg <= '0;
                min_reg   <= '1;
                max_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.mark_overflow)
                    ovf_reg <= 1'b1;
                if (cmd.update)
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + SW'(root_reg);
                    sumsq_reg <= sumsq_reg + QW'(sq_prod);
                    if (root_reg < min_reg)
                        min_reg <= root_reg;
                    if (root_reg > max_reg)
                        max_reg <= root_reg;
                end
            end
        end
    end

    assign status.count_full = (count_reg == CW'(MAX_ITEMS));
    assign status.last_item  = in_reg.last;
    assign status.mul_last   = (mplier_reg[SW-1:1] == '0);

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: design/complex_magnitude_statistics.sv
`timescale 1ns / 1ps
// Top level of the complex magnitude statistics block.
// Instantiates cms_ctrl and cms_datapath; types from cms_pkg.

// An item is taken on a clock edge with start high and busy low. Each accepted
// sample holds busy high through two squaring steps, 16 iterations of the
// bit-per-cycle square root and one update step, so a new sample is not taken
// until the last one is through. A sample that arrives once MAX_ITEMS samples
// are in is dropped on its accept edge and marks the set as overflowed; busy
// stays low unless it carries last, which still closes the set. On the last
// sample of a set busy stays high further while the statistics are finished:
// one setup step, three shift-add multiplies (n*sum_sq, sum^2 and n*n) and
// two restoring divisions (mean, then variance). The result then shows
// on result with done high for exactly one cycle; it cannot be held off, so
// the receiver must take it then. The statistics clear with it and the next
// set may start at once.

module complex_magnitude_statistics #(
    parameter int MAX_ITEMS = cms_pkg::MAX_ITEMS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cms_pkg::cms_in_t  item,
    output logic              done,
    output cms_pkg::cms_out_t result
);
    import cms_pkg::*;

    cms_cmd_t    cmd;
    cms_status_t status;

    cms_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .last   (item.last),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    cms_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .done   (done),
        .result (result)
    );

endmodule
